// ===== hdl/jvmstk_pkg.sv =====
// Types, codes and microcode ROM for the JVM operand stack shuffle block.
// Used by jvm_operand_stack_shuffle_top; depends on nothing else.
package jvmstk_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH    = 4'd0,
    CMD_POP     = 4'd1,
    CMD_POP2    = 4'd2,
    CMD_DUP     = 4'd3,
    CMD_DUP_X1  = 4'd4,
    CMD_DUP_X2  = 4'd5,
    CMD_DUP2    = 4'd6,
    CMD_DUP2_X1 = 4'd7,
    CMD_DUP2_X2 = 4'd8,
    CMD_SWAP    = 4'd9
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PAT_NONE,
    PAT_PUSH,
    PAT_DUP,
    PAT_X1,
    PAT_SWAP,
    PAT_DX2,
    PAT_D2,
    PAT_D2X1,
    PAT_D2X2
  } pat_t;

  typedef enum logic {
    COND_NONE,
    COND_WR_MORE
  } cond_t;

  // Write source: 0..3 select held entry (0 is the top), SRC_PUSH the pushed word.
  localparam logic [2:0] SRC_PUSH = 3'd4;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [63:0] push_value;
    logic               push_wide;
  } cmd_word_t;

  typedef struct packed {
    logic signed [63:0] top_value;
    logic               top_wide;
    logic [6:0]         depth;
    logic [1:0]         status;
  } result_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] k;
    pat_t       pat;
  } dec_t;

  typedef struct packed {
    logic       rd_en;
    logic [1:0] rd_slot;
    logic       cap_en;
    logic [1:0] cap_slot;
    logic       decide;
    logic       wr;
    logic       fin;
    cond_t      cond;
    logic [2:0] jump;
  } uop_t;

  localparam logic [2:0] UPC_WRITE = 3'd6;

  function automatic uop_t ucode(input logic [2:0] upc);
    uop_t u;
    u = '0;
    case (upc)
      3'd0: begin
        u.rd_en = 1'b1; u.rd_slot = 2'd0;
      end
      3'd1: begin
        u.rd_en = 1'b1; u.rd_slot = 2'd1; u.cap_en = 1'b1; u.cap_slot = 2'd0;
      end
      3'd2: begin
        u.rd_en = 1'b1; u.rd_slot = 2'd2; u.cap_en = 1'b1; u.cap_slot = 2'd1;
      end
      3'd3: begin
        u.rd_en = 1'b1; u.rd_slot = 2'd3; u.cap_en = 1'b1; u.cap_slot = 2'd2;
      end
      3'd4: begin
        u.cap_en = 1'b1; u.cap_slot = 2'd3;
      end
      3'd5: begin
        u.decide = 1'b1;
      end
      3'd6: begin
        u.wr = 1'b1; u.cond = COND_WR_MORE; u.jump = UPC_WRITE;
      end
      default: begin
        u.fin = 1'b1;
      end
    endcase
    return u;
  endfunction

  function automatic logic [2:0] pat_len(input pat_t p);
    case (p)
      PAT_PUSH: return 3'd1;
      PAT_DUP:  return 3'd2;
      PAT_X1:   return 3'd3;
      PAT_SWAP: return 3'd2;
      PAT_DX2:  return 3'd4;
      PAT_D2:   return 3'd4;
      PAT_D2X1: return 3'd5;
      PAT_D2X2: return 3'd6;
      default:  return 3'd0;
    endcase
  endfunction

  // Source of the j-th word written, bottom to top.
  function automatic logic [2:0] pat_src(input pat_t p, input logic [2:0] j);
    logic [2:0] s;
    s = 3'd0;
    case (p)
      PAT_PUSH: s = SRC_PUSH;
      PAT_X1:   s = (j == 3'd1) ? 3'd1 : 3'd0;
      PAT_SWAP: s = (j == 3'd1) ? 3'd1 : 3'd0;
      PAT_DX2: begin
        case (j)
          3'd1:    s = 3'd2;
          3'd2:    s = 3'd1;
          default: s = 3'd0;
        endcase
      end
      PAT_D2:   s = j[0] ? 3'd0 : 3'd1;
      PAT_D2X1: begin
        case (j)
          3'd0:    s = 3'd1;
          3'd2:    s = 3'd2;
          3'd3:    s = 3'd1;
          default: s = 3'd0;
        endcase
      end
      PAT_D2X2: begin
        case (j)
          3'd0:    s = 3'd1;
          3'd2:    s = 3'd3;
          3'd3:    s = 3'd2;
          3'd4:    s = 3'd1;
          default: s = 3'd0;
        endcase
      end
      default:  s = 3'd0;
    endcase
    return s;
  endfunction

  // Category check, top entry first. pres/wide bit 0 is the top entry.
  function automatic dec_t decode(input logic [3:0] cmd, input logic [3:0] pres,
                                  input logic [3:0] wide);
    dec_t d;
    d.status = ST_OK;
    d.k      = 3'd0;
    d.pat    = PAT_NONE;
    case (cmd)
      CMD_PUSH: d.pat = PAT_PUSH;
      CMD_POP, CMD_DUP: begin
        if (!pres[0])     d.status = ST_UNDER;
        else if (wide[0]) d.status = ST_ILLEGAL;
        else begin
          d.k = 3'd1;
          d.pat = (cmd == CMD_DUP) ? PAT_DUP : PAT_NONE;
        end
      end
      CMD_POP2, CMD_DUP2: begin
        if (!pres[0]) d.status = ST_UNDER;
        else if (wide[0]) begin
          d.k = 3'd1;
          d.pat = (cmd == CMD_DUP2) ? PAT_DUP : PAT_NONE;
        end else if (!pres[1]) d.status = ST_UNDER;
        else if (wide[1])      d.status = ST_ILLEGAL;
        else begin
          d.k = 3'd2;
          d.pat = (cmd == CMD_DUP2) ? PAT_D2 : PAT_NONE;
        end
      end
      CMD_DUP_X1, CMD_SWAP: begin
        if (!pres[0])      d.status = ST_UNDER;
        else if (wide[0])  d.status = ST_ILLEGAL;
        else if (!pres[1]) d.status = ST_UNDER;
        else if (wide[1])  d.status = ST_ILLEGAL;
        else begin
          d.k = 3'd2;
          d.pat = (cmd == CMD_SWAP) ? PAT_SWAP : PAT_X1;
        end
      end
      CMD_DUP_X2: begin
        if (!pres[0])      d.status = ST_UNDER;
        else if (wide[0])  d.status = ST_ILLEGAL;
        else if (!pres[1]) d.status = ST_UNDER;
        else if (wide[1]) begin
          d.k = 3'd2; d.pat = PAT_X1;
        end else if (!pres[2]) d.status = ST_UNDER;
        else if (wide[2])      d.status = ST_ILLEGAL;
        else begin
          d.k = 3'd3; d.pat = PAT_DX2;
        end
      end
      CMD_DUP2_X1: begin
        if (!pres[0])      d.status = ST_UNDER;
        else if (wide[0]) begin
          if (!pres[1])     d.status = ST_UNDER;
          else if (wide[1]) d.status = ST_ILLEGAL;
          else begin
            d.k = 3'd2; d.pat = PAT_X1;
          end
        end else if (!pres[1]) d.status = ST_UNDER;
        else if (wide[1])      d.status = ST_ILLEGAL;
        else if (!pres[2])     d.status = ST_UNDER;
        else if (wide[2])      d.status = ST_ILLEGAL;
        else begin
          d.k = 3'd3; d.pat = PAT_D2X1;
        end
      end
      CMD_DUP2_X2: begin
        if (!pres[0]) d.status = ST_UNDER;
        else if (wide[0]) begin
          if (!pres[1]) d.status = ST_UNDER;
          else if (wide[1]) begin
            d.k = 3'd2; d.pat = PAT_X1;
          end else if (!pres[2]) d.status = ST_UNDER;
          else if (wide[2])      d.status = ST_ILLEGAL;
          else begin
            d.k = 3'd3; d.pat = PAT_DX2;
          end
        end else if (!pres[1]) d.status = ST_UNDER;
        else if (wide[1])      d.status = ST_ILLEGAL;
        else if (!pres[2])     d.status = ST_UNDER;
        else if (wide[2]) begin
          d.k = 3'd3; d.pat = PAT_D2X1;
        end else if (!pres[3]) d.status = ST_UNDER;
        else if (wide[3])      d.status = ST_ILLEGAL;
        else begin
          d.k = 3'd4; d.pat = PAT_D2X2;
        end
      end
      default: d.status = ST_ILLEGAL;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/jvm_operand_stack_shuffle_top.sv =====
// JVM operand stack with push, pop and the dup/swap category forms.
// Memory-backed stack run by a microcode ROM; depends on jvmstk_pkg.
//
// A command word is taken when start is high and busy is low. Each command
// reads the top four entries of the single-port stack memory, checks the
// categories and the depth, then writes its words to the stack one entry per
// cycle, bottom to top, before the done strobe. The result word is on result
// for exactly the one cycle that done is high and cannot be held off, so it
// must be taken then. busy falls with done, so the next command may be
// started in that cycle.
module jvm_operand_stack_shuffle_top
  import jvmstk_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  cmd_word_t    cmd,
  output logic         done,
  output result_word_t result
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [64:0]    mem [STACK_DEPTH];
  logic [64:0]    mem_q;
  logic [64:0]    tmp [4];
  logic [SPW-1:0] sp;
  logic [SPW-1:0] base;
  logic [SPW-1:0] newsp;
  logic [2:0]     upc;
  logic [2:0]     widx;
  cmd_word_t      cmd_r;
  logic [1:0]     dec_st;
  logic [2:0]     dec_k;
  pat_t           dec_pat;

  uop_t           u;
  dec_t           d;
  logic [3:0]     pres;
  logic [3:0]     wide;
  logic [SPW:0]   grow;
  logic [SPW-1:0] rd_addr;
  logic [SPW-1:0] wr_addr;
  logic [2:0]     src;
  logic [64:0]    wr_data;
  logic           wr_en;
  logic           taken;
  logic [2:0]     len;
  logic           dec_ok;
  logic [SPW-1:0] fin_sp;
  logic [SPW+6:0] fin_sp_ext;
  logic [64:0]    top;

  assign u      = ucode(upc);
  assign len    = pat_len(dec_pat);
  assign dec_ok = (dec_st == ST_OK);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pres[i] = (SPW'(i + 1) <= sp);
      wide[i] = tmp[i][64];
    end
  end

  assign d    = decode(cmd_r.command, pres, wide);
  assign grow = {1'b0, sp} - (SPW + 1)'(d.k) + (SPW + 1)'(pat_len(d.pat));

  assign rd_addr = sp - SPW'(u.rd_slot) - SPW'(1);
  assign wr_addr = base + SPW'(widx);
  assign src     = pat_src(dec_pat, widx);
  assign wr_data = (src == SRC_PUSH) ? {cmd_r.push_wide, cmd_r.push_value} : tmp[src[1:0]];
  assign wr_en   = busy && u.wr && dec_ok && (widx < len);
  assign taken   = (u.cond == COND_WR_MORE) && dec_ok && ((widx + 3'd1) < len);

  assign fin_sp     = dec_ok ? newsp : sp;
  assign fin_sp_ext = {7'b0, fin_sp};

  always_comb begin
    if (fin_sp == '0) begin
      top = '0;
    end else if (dec_ok && dec_pat == PAT_PUSH) begin
      top = {cmd_r.push_wide, cmd_r.push_value};
    end else if (dec_ok && dec_pat == PAT_SWAP) begin
      top = tmp[1];
    end else if (dec_ok && len == 3'd0) begin
      top = tmp[dec_k[1:0]];
    end else begin
      top = tmp[0];
    end
  end

  always_ff @(posedge clk) begin
    if (busy && u.rd_en) begin
      mem_q <= mem[rd_addr[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd;
    end
    if (busy && u.cap_en) begin
      tmp[u.cap_slot] <= mem_q;
    end
    if (busy && u.decide) begin
      dec_pat <= d.pat;
      dec_k   <= d.k;
      base    <= sp - SPW'(d.k);
      newsp   <= grow[SPW-1:0];
      if (d.status == ST_OK && grow > (SPW + 1)'(STACK_DEPTH)) begin
        dec_st <= ST_OVER;
      end else begin
        dec_st <= d.status;
      end
    end
    if (busy && u.fin) begin
      result.top_value <= top[63:0];
      result.top_wide  <= top[64];
      result.depth     <= fin_sp_ext[6:0];
      result.status    <= dec_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      sp   <= '0;
      upc  <= '0;
      widx <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          upc  <= '0;
        end
      end else begin
        upc <= taken ? u.jump : upc + 3'd1;
        if (u.decide) begin
          widx <= '0;
        end else if (taken) begin
          widx <= widx + 3'd1;
        end
        if (u.fin) begin
          busy <= 1'b0;
          done <= 1'b1;
          sp   <= fin_sp;
        end
      end
    end
  end

`ifndef SYNTH
  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
      sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
      start && !busy |=> busy && !done)
    else $error("accepted command not busy");
  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
      busy && u.fin && !dec_ok |=> sp == $past(sp))
    else $error("failed command moved stack pointer");
`endif

endmodule
